[rtl/spo_pkg.sv]
// Package for the shape pair overlap test: constants, pipeline side-band type
// and the shared square-root step. No dependencies.
package spo_pkg;

    // fraction bits of the contact normal
    localparam int NORMAL_FRAC_BITS = 14;

    // pair kinds, {a_is_circle, b_is_circle}
    localparam logic [1:0] MODE_BB = 2'b00;
    localparam logic [1:0] MODE_BC = 2'b01;
    localparam logic [1:0] MODE_CB = 2'b10;
    localparam logic [1:0] MODE_CC = 2'b11;

    // largest normal magnitude the 16-bit field holds
    localparam logic [15:0] NRM_MAX = 16'd32767;
    // unit normal along an axis, saturated to the field
    localparam logic [15:0] NRM_ONE =
        16'(((1 << NORMAL_FRAC_BITS) > 32767) ? 32767 : (1 << NORMAL_FRAC_BITS));

    // pipeline depths
    localparam int DIV_ST = 2 * NORMAL_FRAC_BITS + 1;  // quotient bits
    localparam int QW     = DIV_ST;
    localparam int NSQ_ST = NORMAL_FRAC_BITS + 1;      // root bits of the normal
    localparam int NOW    = 2 * NSQ_ST;                // padded quotient width
    localparam int DSQ_ST = 21;                        // root bits of the distance
    localparam int TAIL   = DIV_ST + NSQ_ST;

    // square-root partial state
    typedef struct packed {
        logic [23:0] rem;
        logic [21:0] root;
    } t_sqs;

    // side-band data that travels with each item
    typedef struct packed {
        logic        circ;
        logic        hit;
        logic        big;
        logic        sgn_x;
        logic        sgn_y;
        logic        zero;
        logic [15:0] nx_box;
        logic [15:0] ny_box;
        logic [20:0] pen;
    } t_side;

    // one digit of the restoring square root: bring in two bits, try 4*root+1
    function automatic t_sqs sqrt_step(t_sqs cur, logic [1:0] pr);
        logic [23:0] rm;
        logic [23:0] tr;
        t_sqs        nx;
        rm = {cur.rem[21:0], pr};
        tr = {cur.root, 2'b01};
        if (rm >= tr) begin
            nx.rem  = rm - tr;
            nx.root = {cur.root[20:0], 1'b1};
        end else begin
            nx.rem  = rm;
            nx.root = {cur.root[20:0], 1'b0};
        end
        return nx;
    endfunction

endpackage

[rtl/shape_pair_overlap_test.sv]
// Top level of the shape pair overlap test: box/circle narrow-phase pipeline.
// Depends on spo_pkg for constants, the side-band type and the root step.
//
//  channel   handshake              fields
//  input     start / busy           i_a_*, i_b_*  (shape, centre, sizes)
//  result    o_strobe (one cycle)   o_hit, o_normal_x, o_normal_y, o_penetration
//
// One item enters per cycle; busy stays low. The pipeline depth is set by the
// one-bit-per-stage divider for the normal and the square root that follows it.
// Reset clears only the valid bits; there is no clearing pass.
// The receiver cannot stall, so every stage advances each cycle.
module shape_pair_overlap_test
    import spo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_a_is_circle,
    input  logic               i_b_is_circle,
    input  logic signed [23:0] i_a_x,
    input  logic signed [23:0] i_a_y,
    input  logic        [19:0] i_a_size_x,
    input  logic        [19:0] i_a_size_y,
    input  logic signed [23:0] i_b_x,
    input  logic signed [23:0] i_b_y,
    input  logic        [19:0] i_b_size_x,
    input  logic        [19:0] i_b_size_y,
    output logic               o_strobe,
    output logic               o_hit,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic        [20:0] o_penetration
);

    assign busy = 1'b0;

    // ---------------- stage 1: pick roles and centre differences ----------
    logic               r_v1;
    logic               r1_circ;
    logic signed [24:0] r1_d0x, r1_d0y;
    logic        [20:0] r1_hw, r1_hh, r1_rad;
    logic signed [24:0] n1_d0x, n1_d0y;
    logic        [20:0] n1_hw, n1_hh, n1_rad;

    always_comb begin
        unique case ({i_a_is_circle, i_b_is_circle})
            MODE_BC: begin
                n1_d0x = {i_b_x[23], i_b_x} - {i_a_x[23], i_a_x};
                n1_d0y = {i_b_y[23], i_b_y} - {i_a_y[23], i_a_y};
                n1_hw  = {1'b0, i_a_size_x};
                n1_hh  = {1'b0, i_a_size_y};
                n1_rad = {1'b0, i_b_size_x};
            end
            MODE_CB: begin
                n1_d0x = {i_a_x[23], i_a_x} - {i_b_x[23], i_b_x};
                n1_d0y = {i_a_y[23], i_a_y} - {i_b_y[23], i_b_y};
                n1_hw  = {1'b0, i_b_size_x};
                n1_hh  = {1'b0, i_b_size_y};
                n1_rad = {1'b0, i_a_size_x};
            end
            MODE_CC: begin
                n1_d0x = {i_b_x[23], i_b_x} - {i_a_x[23], i_a_x};
                n1_d0y = {i_b_y[23], i_b_y} - {i_a_y[23], i_a_y};
                n1_hw  = '0;
                n1_hh  = '0;
                n1_rad = {1'b0, i_a_size_x} + {1'b0, i_b_size_x};
            end
            default: begin
                n1_d0x = {i_a_x[23], i_a_x} - {i_b_x[23], i_b_x};
                n1_d0y = {i_a_y[23], i_a_y} - {i_b_y[23], i_b_y};
                n1_hw  = {1'b0, i_a_size_x} + {1'b0, i_b_size_x};
                n1_hh  = {1'b0, i_a_size_y} + {1'b0, i_b_size_y};
                n1_rad = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
        r1_circ <= i_a_is_circle || i_b_is_circle;
        r1_d0x  <= n1_d0x;
        r1_d0y  <= n1_d0y;
        r1_hw   <= n1_hw;
        r1_hh   <= n1_hh;
        r1_rad  <= n1_rad;
    end

    // ---------------- stage 2: clamp to box, box pair result -------------
    logic               r_v2;
    t_side              r2_side;
    logic signed [21:0] r2_dx, r2_dy;
    t_side              n2_side;
    logic signed [25:0] n2_cx, n2_cy;
    logic signed [25:0] e0x, e0y, hwe, hhe;
    logic        [24:0] abx, aby;
    logic        [20:0] ovx, ovy;
    logic               hitb;

    always_comb begin
        // clamp the centre difference to the box extent
        e0x = {r1_d0x[24], r1_d0x};
        e0y = {r1_d0y[24], r1_d0y};
        hwe = signed'({5'b0, r1_hw});
        hhe = signed'({5'b0, r1_hh});
        if (e0x > hwe) begin
            n2_cx = e0x - hwe;
        end else if (e0x < -hwe) begin
            n2_cx = e0x + hwe;
        end else begin
            n2_cx = '0;
        end
        if (e0y > hhe) begin
            n2_cy = e0y - hhe;
        end else if (e0y < -hhe) begin
            n2_cy = e0y + hhe;
        end else begin
            n2_cy = '0;
        end

        // box pair: overlap on both axes, pick the axis of least overlap
        abx  = r1_d0x[24] ? 25'(-r1_d0x) : 25'(r1_d0x);
        aby  = r1_d0y[24] ? 25'(-r1_d0y) : 25'(r1_d0y);
        hitb = (abx < {4'b0, r1_hw}) && (aby < {4'b0, r1_hh});
        ovx  = r1_hw - abx[20:0];
        ovy  = r1_hh - aby[20:0];

        n2_side.circ  = r1_circ;
        n2_side.big   = (n2_cx >= 26'sd2097152) || (n2_cx <= -26'sd2097152) ||
                        (n2_cy >= 26'sd2097152) || (n2_cy <= -26'sd2097152);
        n2_side.sgn_x = n2_cx[25];
        n2_side.sgn_y = n2_cy[25];
        n2_side.zero  = 1'b0;
        n2_side.hit   = hitb;
        if (r1_circ) begin
            n2_side.nx_box = '0;
            n2_side.ny_box = '0;
            n2_side.pen    = r1_rad;
        end else if (ovx > ovy) begin
            n2_side.nx_box = '0;
            n2_side.ny_box = r1_d0y[24] ? NRM_ONE : 16'(-NRM_ONE);
            n2_side.pen    = ovy;
        end else begin
            n2_side.nx_box = r1_d0x[24] ? NRM_ONE : 16'(-NRM_ONE);
            n2_side.ny_box = '0;
            n2_side.pen    = ovx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r2_side <= n2_side;
        r2_dx   <= n2_cx[21:0];
        r2_dy   <= n2_cy[21:0];
    end

    // ---------------- stage 3: squares ------------------------------------
    logic               r_v3;
    t_side              r3_side;
    logic        [41:0] r3_sqx, r3_sqy, r3_rad2;
    logic signed [43:0] n3_px, n3_py;
    logic        [41:0] n3_rad2;

    assign n3_px   = r2_dx * r2_dx;
    assign n3_py   = r2_dy * r2_dy;
    assign n3_rad2 = {21'b0, r2_side.pen} * {21'b0, r2_side.pen};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r3_side <= r2_side;
        r3_sqx  <= n3_px[41:0];
        r3_sqy  <= n3_py[41:0];
        r3_rad2 <= n3_rad2;
    end

    // ---------------- stage 4: squared distance and circle hit ------------
    logic        [TAIL:0] r_vt;
    t_side                r_sd  [0:TAIL];
    logic        [41:0]   r_s   [0:DIV_ST-1];
    logic        [42:0]   r_rx  [0:DIV_ST-1];
    logic        [42:0]   r_ry  [0:DIV_ST-1];
    logic        [42:0]   n4_sum;
    t_side                n4_side;

    always_comb begin
        n4_sum  = {1'b0, r3_sqx} + {1'b0, r3_sqy};
        n4_side = r3_side;
        if (r3_side.circ) begin
            n4_side.hit = !r3_side.big && (n4_sum < {1'b0, r3_rad2});
        end
    end

    // advance the valid bits of the whole tail
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vt <= '0;
        end else begin
            r_vt <= {r_vt[TAIL-1:0], r_v3};
        end
        r_sd[0] <= n4_side;
        r_s[0]  <= n4_sum[41:0];
        r_rx[0] <= {1'b0, r3_sqx};
        r_ry[0] <= {1'b0, r3_sqy};
    end

    // ---------------- tail: side-band ------------------------------------
    logic [QW-1:0] r_qx [1:DIV_ST];
    logic [QW-1:0] r_qy [1:DIV_ST];
    t_sqs          r_ds [1:DSQ_ST];

    genvar gi;
    generate
        for (gi = 1; gi <= TAIL; gi++) begin : g_side
            if (gi == 1) begin : g_zero
                // flag a zero-length vector
                always_ff @(posedge i_clk) begin
                    t_side sz;
                    sz       = r_sd[gi-1];
                    sz.zero  = (r_s[0] == '0);
                    r_sd[gi] <= sz;
                end
            end else if (gi == DSQ_ST + 1) begin : g_pen
                // penetration of a circle pair is radius minus the distance
                always_ff @(posedge i_clk) begin
                    t_side sp;
                    sp = r_sd[gi-1];
                    if (sp.circ) begin
                        sp.pen = sp.pen - r_ds[DSQ_ST].root[20:0];
                    end
                    r_sd[gi] <= sp;
                end
            end else begin : g_copy
                always_ff @(posedge i_clk) begin
                    r_sd[gi] <= r_sd[gi-1];
                end
            end
        end

        // ---------------- distance square root, one root bit a stage ------
        logic [41:0] r_dop [1:DSQ_ST-1];
        for (gi = 1; gi <= DSQ_ST; gi++) begin : g_dsq
            if (gi == 1) begin : g_first
                always_ff @(posedge i_clk) begin
                    r_ds[gi]  <= sqrt_step('0, r_s[0][41:40]);
                    r_dop[gi] <= {r_s[0][39:0], 2'b00};
                end
            end else if (gi < DSQ_ST) begin : g_mid
                always_ff @(posedge i_clk) begin
                    r_ds[gi]  <= sqrt_step(r_ds[gi-1], r_dop[gi-1][41:40]);
                    r_dop[gi] <= {r_dop[gi-1][39:0], 2'b00};
                end
            end else begin : g_last
                always_ff @(posedge i_clk) begin
                    r_ds[gi] <= sqrt_step(r_ds[gi-1], r_dop[gi-1][41:40]);
                end
            end
        end

        // ---------------- divider d^2 * 2^(2F) / s, one quotient bit a stage
        for (gi = 1; gi <= DIV_ST; gi++) begin : g_div
            logic [42:0] tx, ty, sx;
            logic        bx, by;
            if (gi == 1) begin : g_t0
                assign tx = r_rx[0];
                assign ty = r_ry[0];
            end else begin : g_tn
                assign tx = {r_rx[gi-1][41:0], 1'b0};
                assign ty = {r_ry[gi-1][41:0], 1'b0};
            end
            assign sx = {1'b0, r_s[gi-1]};
            assign bx = (tx >= sx);
            assign by = (ty >= sx);
            if (gi == 1) begin : g_q0
                always_ff @(posedge i_clk) begin
                    r_qx[gi] <= {{(QW-1){1'b0}}, bx};
                    r_qy[gi] <= {{(QW-1){1'b0}}, by};
                end
            end else begin : g_qn
                always_ff @(posedge i_clk) begin
                    r_qx[gi] <= {r_qx[gi-1][QW-2:0], bx};
                    r_qy[gi] <= {r_qy[gi-1][QW-2:0], by};
                end
            end
            if (gi < DIV_ST) begin : g_rem
                always_ff @(posedge i_clk) begin
                    r_rx[gi] <= bx ? tx - sx : tx;
                    r_ry[gi] <= by ? ty - sx : ty;
                    r_s[gi]  <= r_s[gi-1];
                end
            end
        end

        // ---------------- normal square root, one root bit a stage --------
        logic [NOW-1:0] w_nox0, w_noy0;
        t_sqs           r_nsx [1:NSQ_ST];
        t_sqs           r_nsy [1:NSQ_ST];
        logic [NOW-1:0] r_nox [1:NSQ_ST-1];
        logic [NOW-1:0] r_noy [1:NSQ_ST-1];
        assign w_nox0 = {1'b0, r_qx[DIV_ST]};
        assign w_noy0 = {1'b0, r_qy[DIV_ST]};
        for (gi = 1; gi <= NSQ_ST; gi++) begin : g_nsq
            if (gi == 1) begin : g_first
                always_ff @(posedge i_clk) begin
                    r_nsx[gi] <= sqrt_step('0, w_nox0[NOW-1:NOW-2]);
                    r_nsy[gi] <= sqrt_step('0, w_noy0[NOW-1:NOW-2]);
                    r_nox[gi] <= {w_nox0[NOW-3:0], 2'b00};
                    r_noy[gi] <= {w_noy0[NOW-3:0], 2'b00};
                end
            end else if (gi < NSQ_ST) begin : g_mid
                always_ff @(posedge i_clk) begin
                    r_nsx[gi] <= sqrt_step(r_nsx[gi-1], r_nox[gi-1][NOW-1:NOW-2]);
                    r_nsy[gi] <= sqrt_step(r_nsy[gi-1], r_noy[gi-1][NOW-1:NOW-2]);
                    r_nox[gi] <= {r_nox[gi-1][NOW-3:0], 2'b00};
                    r_noy[gi] <= {r_noy[gi-1][NOW-3:0], 2'b00};
                end
            end else begin : g_last
                always_ff @(posedge i_clk) begin
                    r_nsx[gi] <= sqrt_step(r_nsx[gi-1], r_nox[gi-1][NOW-1:NOW-2]);
                    r_nsy[gi] <= sqrt_step(r_nsy[gi-1], r_noy[gi-1][NOW-1:NOW-2]);
                end
            end
        end

        // ---------------- output register -------------------------------
        t_side       fs;
        logic [15:0] mx, my;
        logic [15:0] n_nx, n_ny;
        logic [20:0] n_pen;
        assign fs = r_sd[TAIL];
        always_comb begin
            mx = (r_nsx[NSQ_ST].root > {6'b0, NRM_MAX}) ? NRM_MAX
                                                        : r_nsx[NSQ_ST].root[15:0];
            my = (r_nsy[NSQ_ST].root > {6'b0, NRM_MAX}) ? NRM_MAX
                                                        : r_nsy[NSQ_ST].root[15:0];
            if (!fs.hit) begin
                n_nx  = '0;
                n_ny  = '0;
                n_pen = '0;
            end else if (!fs.circ) begin
                n_nx  = fs.nx_box;
                n_ny  = fs.ny_box;
                n_pen = fs.pen;
            end else if (fs.zero) begin
                n_nx  = '0;
                n_ny  = '0;
                n_pen = fs.pen;
            end else begin
                n_nx  = fs.sgn_x ? 16'(-mx) : mx;
                n_ny  = fs.sgn_y ? 16'(-my) : my;
                n_pen = fs.pen;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                o_strobe <= 1'b0;
            end else begin
                o_strobe <= r_vt[TAIL];
            end
            o_hit         <= fs.hit;
            o_normal_x    <= n_nx;
            o_normal_y    <= n_ny;
            o_penetration <= n_pen;
        end
    endgenerate

    // ---------------- assertions ----------------------------------------
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> r_v1)
        else $error("accepted item did not enter the pipeline");

    a_leave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vt[TAIL] |=> o_strobe)
        else $error("item at the pipeline end produced no result");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_hit) |->
        (o_normal_x == '0 && o_normal_y == '0 && o_penetration == '0))
        else $error("miss result carries nonzero fields");

    a_hit_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_hit) |-> (o_penetration != '0))
        else $error("hit result with zero penetration");

endmodule

[dv/shape_pair_overlap_check.sv]
// Checker for the shape pair overlap test: watches the item and result
// channels, predicts each contact and compares field by field.
// Depends on spo_pkg for the pair kinds and the normal fraction bits.
`timescale 1ns / 1ps

module shape_pair_overlap_check
    import spo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               i_a_is_circle,
    input  logic               i_b_is_circle,
    input  logic signed [23:0] i_a_x,
    input  logic signed [23:0] i_a_y,
    input  logic        [19:0] i_a_size_x,
    input  logic        [19:0] i_a_size_y,
    input  logic signed [23:0] i_b_x,
    input  logic signed [23:0] i_b_y,
    input  logic        [19:0] i_b_size_x,
    input  logic        [19:0] i_b_size_y,
    input  logic               o_strobe,
    input  logic               o_hit,
    input  logic signed [15:0] o_normal_x,
    input  logic signed [15:0] o_normal_y,
    input  logic        [20:0] o_penetration,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct packed {
        logic               hit;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic        [20:0] pen;
    } t_contact;

    t_contact pending_contacts[$];

    // floor square root, digit by digit
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    // one unit-vector component: trunc(d * 2^F / sqrt(len2)), saturated
    function automatic longint unit_part(longint d, longint unsigned len2);
        longint unsigned mag2, q, r, m;
        if (len2 == 0) return 0;
        mag2 = (d < 0) ? longint'(-d) * longint'(-d) : d * d;
        q = mag2 / len2;
        r = mag2 % len2;
        for (int i = 0; i < 2 * NORMAL_FRAC_BITS; i++) begin
            r <<= 1;
            q <<= 1;
            if (r >= len2) begin
                r -= len2;
                q |= 1;
            end
        end
        m = floor_sqrt(q);
        if (m > 32767) m = 32767;
        return (d < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v;
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // box against circle; normal runs from the nearest box point to the centre
    function automatic t_contact box_vs_circle(longint bx, longint by, longint hw,
                                               longint hh, longint cx, longint cy,
                                               longint rad);
        t_contact c;
        longint dx, dy;
        longint unsigned len2;
        c = '0;
        dx = cx - clip(cx, bx - hw, bx + hw);
        dy = cy - clip(cy, by - hh, by + hh);
        len2 = dx * dx + dy * dy;
        if (len2 < rad * rad) begin
            c.hit = 1'b1;
            c.nx  = 16'(unit_part(dx, len2));
            c.ny  = 16'(unit_part(dy, len2));
            c.pen = 21'(rad - longint'(floor_sqrt(len2)));
        end
        return c;
    endfunction

    function automatic t_contact predict_contact(
        logic ac, logic bc, longint ax, longint ay, longint asx, longint asy,
        longint bx, longint by, longint bsx, longint bsy);
        t_contact c;
        longint dx, dy, hx, hy, radii, one, nx, ny;
        longint unsigned len2;
        c = '0;
        one = longint'(1) << NORMAL_FRAC_BITS;
        case ({ac, bc})
            MODE_BC: c = box_vs_circle(ax, ay, asx, asy, bx, by, bsx);
            MODE_CB: c = box_vs_circle(bx, by, bsx, bsy, ax, ay, asx);
            MODE_CC: begin
                dx = bx - ax;
                dy = by - ay;
                radii = asx + bsx;
                len2 = dx * dx + dy * dy;
                if (len2 < radii * radii) begin
                    c.hit = 1'b1;
                    c.nx  = 16'(unit_part(dx, len2));
                    c.ny  = 16'(unit_part(dy, len2));
                    c.pen = 21'(radii - longint'(floor_sqrt(len2)));
                end
            end
            default: begin
                dx = ax - bx;
                dy = ay - by;
                hx = asx + bsx;
                hy = asy + bsy;
                if (mag(dx) < hx && mag(dy) < hy) begin
                    nx = 0;
                    ny = 0;
                    c.hit = 1'b1;
                    // ties go to the x axis
                    if (hx - mag(dx) > hy - mag(dy)) begin
                        ny = (dy >= 0) ? -one : one;
                        c.pen = 21'(hy - mag(dy));
                    end else begin
                        nx = (dx >= 0) ? -one : one;
                        c.pen = 21'(hx - mag(dx));
                    end
                    c.nx = 16'(clip(nx, -32767, 32767));
                    c.ny = 16'(clip(ny, -32767, 32767));
                end
            end
        endcase
        return c;
    endfunction

    assign o_pending = pending_contacts.size();

    // predict on each accepted item, compare each strobed result
    always @(posedge i_clk) begin
        t_contact want;
        int       bad;
        bad = 0;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (start && !busy)
                pending_contacts.push_back(predict_contact(i_a_is_circle, i_b_is_circle,
                    i_a_x, i_a_y, i_a_size_x, i_a_size_y,
                    i_b_x, i_b_y, i_b_size_x, i_b_size_y));
            if (o_strobe) begin
                if (pending_contacts.size() == 0) begin
                    $error("result with no item waiting");
                    bad++;
                end else begin
                    want = pending_contacts.pop_front();
                    if (o_hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, o_hit);
                        bad++;
                    end
                    if (o_normal_x !== want.nx) begin
                        $error("normal_x: expected %0d, got %0d", want.nx, o_normal_x);
                        bad++;
                    end
                    if (o_normal_y !== want.ny) begin
                        $error("normal_y: expected %0d, got %0d", want.ny, o_normal_y);
                        bad++;
                    end
                    if (o_penetration !== want.pen) begin
                        $error("penetration: expected %0d, got %0d", want.pen,
                               o_penetration);
                        bad++;
                    end
                end
            end
            o_errors <= o_errors + bad;
        end
    end

endmodule

[dv/testbench.sv]
// Top of the shape pair overlap test bench: clock, reset, stimulus, verdict.
// Depends on spo_pkg, shape_pair_overlap_test and shape_pair_overlap_check.
`timescale 1ns / 1ps

module testbench
    import spo_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN       = 80;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               a_circ = 1'b0, b_circ = 1'b0;
    logic signed [23:0] a_x = '0, a_y = '0, b_x = '0, b_y = '0;
    logic        [19:0] a_sx = '0, a_sy = '0, b_sx = '0, b_sy = '0;
    logic               o_strobe, o_hit;
    logic signed [15:0] o_normal_x, o_normal_y;
    logic        [20:0] o_penetration;
    int                 errors, pending;
    int                 cycles = 0;
    int                 burst_left = 0;

    always #4 i_clk = ~i_clk;

    shape_pair_overlap_test dut (
        .i_clk, .i_rst_n, .start, .busy,
        .i_a_is_circle(a_circ), .i_b_is_circle(b_circ),
        .i_a_x(a_x), .i_a_y(a_y), .i_a_size_x(a_sx), .i_a_size_y(a_sy),
        .i_b_x(b_x), .i_b_y(b_y), .i_b_size_x(b_sx), .i_b_size_y(b_sy),
        .o_strobe, .o_hit, .o_normal_x, .o_normal_y, .o_penetration
    );

    shape_pair_overlap_check checker_i (
        .i_clk, .i_rst_n, .start, .busy,
        .i_a_is_circle(a_circ), .i_b_is_circle(b_circ),
        .i_a_x(a_x), .i_a_y(a_y), .i_a_size_x(a_sx), .i_a_size_y(a_sy),
        .i_b_x(b_x), .i_b_y(b_y), .i_b_size_x(b_sx), .i_b_size_y(b_sy),
        .o_strobe, .o_hit, .o_normal_x, .o_normal_y, .o_penetration,
        .o_errors(errors), .o_pending(pending)
    );

    // stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // present one pair and hold it until taken; a gap may come before each burst
    task automatic send_pair(logic [1:0] kind, logic signed [23:0] ax, ay,
                             logic [19:0] asx, asy, logic signed [23:0] bx, by,
                             logic [19:0] bsx, bsy);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        start  <= 1'b1;
        {a_circ, b_circ} <= kind;
        a_x <= ax; a_y <= ay; a_sx <= asx; a_sy <= asy;
        b_x <= bx; b_y <= by; b_sx <= bsx; b_sy <= bsy;
        do @(posedge i_clk); while (busy);
        burst_left--;
    endtask

    initial begin
        logic [1:0]         kind;
        logic signed [23:0] ax, ay, bx, by;
        logic [19:0]        asx, asy, bsx, bsy;
        int                 spread;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: overlap of each kind, misses, edges, zero-length normals
        send_pair(MODE_BB, 0, 0, 256, 256, 100, 50, 256, 256);
        send_pair(MODE_BB, 0, 0, 256, 256, 0, 0, 256, 256);        // tie, centres equal
        send_pair(MODE_BB, 0, 0, 256, 512, 0, 300, 256, 512);      // offset in y, x axis wins
        send_pair(MODE_BB, 0, 0, 256, 256, 512, 0, 256, 256);      // touching, no hit
        send_pair(MODE_BB, -24'sd8388608, 24'sd8388607, '1, '1,
                  24'sd8388607, -24'sd8388608, '1, '1);
        send_pair(MODE_BB, 24'sd8388607, 24'sd8388607, '1, '1,
                  24'sd8388607, 24'sd8388607, '1, '1);
        send_pair(MODE_BC, 0, 0, 256, 256, 300, 100, 100, 0);
        send_pair(MODE_BC, 0, 0, 256, 256, 10, 10, 50, 0);         // centre inside box
        send_pair(MODE_BC, 0, 0, 256, 256, 356, 0, 100, 0);        // touching
        send_pair(MODE_CB, 400, -400, 300, '1, 0, 0, 256, 256);
        send_pair(MODE_CB, 0, 0, 10, 0, 0, 0, 0, 0);               // zero box
        send_pair(MODE_CB, -24'sd8388608, -24'sd8388608, '1, '1,
                  24'sd8388607, 24'sd8388607, '1, '1);
        send_pair(MODE_CC, 0, 0, 300, 0, 200, -150, 300, 0);
        send_pair(MODE_CC, 5, 5, 1, 0, 5, 5, 1, 0);                // same centre
        send_pair(MODE_CC, 0, 0, 100, 0, 200, 0, 100, 0);          // touching
        send_pair(MODE_CC, 0, 0, 0, 0, 0, 0, 0, 0);                // zero radii
        send_pair(MODE_CC, -24'sd8388608, 24'sd8388607, '1, '1,
                  24'sd8388607, -24'sd8388608, '1, '1);
        send_pair(MODE_CC, 0, 0, '1, 0, 24'sd8388607, 24'sd8388607, '1, 0);

        // random pairs, mostly close enough to touch
        repeat (1500) begin
            kind = 2'($urandom_range(0, 3));
            ax = 24'($urandom);
            ay = 24'($urandom);
            if ($urandom_range(0, 9) == 0) begin
                bx = 24'($urandom); by = 24'($urandom);
                asx = 20'($urandom); asy = 20'($urandom);
                bsx = 20'($urandom); bsy = 20'($urandom);
            end else begin
                spread = 1 << $urandom_range(2, 16);
                bx = ax + 24'(int'($urandom_range(0, 2 * spread)) - spread);
                by = ay + 24'(int'($urandom_range(0, 2 * spread)) - spread);
                asx = 20'($urandom_range(0, spread));
                asy = 20'($urandom_range(0, spread));
                bsx = 20'($urandom_range(0, spread));
                bsy = 20'($urandom_range(0, spread));
            end
            send_pair(kind, ax, ay, asx, asy, bx, by, bsx, bsy);
        end
        start <= 1'b0;

        // drain the pipeline
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
